/* sv/prc_pkg.sv */
// ----------------------------------------------------------------------------
// prc_pkg: shared types and constants of the pot reading conditioner
// Word layouts of both channels, register indexes and the fixed field widths.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int ADC_BITS   = 12;
  localparam int FRAC_BITS  = 16;
  localparam int COEF_BITS  = 8;
  localparam int EDGE_BITS  = 7;
  localparam int THR_BITS   = 12;
  localparam int MS_BITS    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CAL_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_FRAC  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = 3'd6;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_POLL = 1'b1;

  typedef struct packed {
    logic                op;
    logic [ADC_BITS-1:0] adc_sample;
  } req_word_t;

  typedef struct packed {
    logic                 changed;
    logic [FRAC_BITS-1:0] position;
  } rsp_word_t;

endpackage

/* sv/pot_reading_conditioner.sv */
// ----------------------------------------------------------------------------
// pot_reading_conditioner: potentiometer reading conditioner
// Interval gating, calibration clamp, IIR smoothing, hysteresis and a
// bit-serial conversion of the filtered reading to a Q0.16 fraction.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_stall, req) carries one word per tick
//   or poll. Every accepted word yields exactly one word on the response
//   channel (rsp_valid, rsp_stall, rsp); changed is 0 when nothing new is
//   reported, and then position is 0.
//   A tick, or a poll that comes before the sample interval has passed, goes
//   straight to the output stage. A full poll runs shift-add for the IIR and
//   trim products, then limit checks and, when a fraction must be computed,
//   restoring division at one quotient bit per cycle.
//   One word is in work at a time; req_stall is high until the result has
//   been moved into the output register.
//   The output register holds one result; while rsp_stall is high the block
//   still finishes its current word and then waits for the register to free.
//   Synchronous reset restores the register defaults, clears the timer, the
//   filter and the last reported value, and empties the output register.
//   Configuration is written through cfg_write, cfg_index and cfg_data.
module pot_reading_conditioner (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  prc_pkg::req_word_t                   req,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output prc_pkg::rsp_word_t                   rsp,
  input  logic                                 cfg_write,
  input  logic [prc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [prc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int ADC_BITS  = prc_pkg::ADC_BITS;
  localparam int FRAC_BITS = prc_pkg::FRAC_BITS;
  localparam int COEF_BITS = prc_pkg::COEF_BITS;
  localparam int EDGE_BITS = prc_pkg::EDGE_BITS;
  localparam int PROD_W    = ADC_BITS + COEF_BITS;
  localparam int TRIM_W    = ADC_BITS + EDGE_BITS;
  localparam int SH_W      = COEF_BITS + 1;
  localparam int CNT_W     = $clog2((FRAC_BITS > SH_W) ? FRAC_BITS : SH_W);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_TRIM = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;

  // Configuration registers
  logic [ADC_BITS-1:0]          cal_min;
  logic [ADC_BITS-1:0]          cal_max;
  logic                         invert_direction;
  logic [EDGE_BITS-1:0]         edge_fraction;
  logic [COEF_BITS-1:0]         smoothing_coeff;
  logic [prc_pkg::THR_BITS-1:0] change_threshold;
  logic [prc_pkg::MS_BITS-1:0]  sample_interval_ms;

  // Block state
  logic [prc_pkg::MS_BITS-1:0]  elapsed_ms;
  logic [ADC_BITS-1:0]          filtered_value;
  logic [ADC_BITS-1:0]          last_reported;

  // Sequencer and datapath
  logic [2:0]                   state;
  logic [CNT_W-1:0]             cnt;
  logic [ADC_BITS-1:0]          samp;
  logic [SH_W-1:0]              a_sh;
  logic [SH_W-1:0]              c_sh;
  logic [SH_W-1:0]              e_sh;
  logic [PROD_W-1:0]            acc_f;
  logic [TRIM_W-1:0]            acc_t;
  logic [ADC_BITS-1:0]          tmin;
  logic [ADC_BITS-1:0]          tmax;
  logic [ADC_BITS-1:0]          rem;
  logic [ADC_BITS-1:0]          den;
  logic [FRAC_BITS-1:0]         quo;
  logic                         res_changed;
  logic [FRAC_BITS-1:0]         res_pos;

  logic [ADC_BITS-1:0]          hi;
  logic [ADC_BITS-1:0]          range;
  logic [ADC_BITS-1:0]          samp_cl;
  logic [ADC_BITS-1:0]          f;
  logic [ADC_BITS-1:0]          diff;
  logic [ADC_BITS:0]            rem2;
  logic                         ge;
  logic                         req_take;
  logic                         rsp_free;

  assign hi       = (cal_max < cal_min) ? cal_min : cal_max;
  assign range    = hi - cal_min;
  assign samp_cl  = (req.adc_sample < cal_min) ? cal_min :
                    (req.adc_sample > hi) ? hi : req.adc_sample;
  assign f        = acc_f[PROD_W-1:COEF_BITS];
  assign diff     = (f > last_reported) ? f - last_reported : last_reported - f;
  assign rem2     = {rem, 1'b0};
  assign ge       = rem2 >= {1'b0, den};
  assign req_stall = (state != S_IDLE);
  assign req_take = req_valid && !req_stall;
  assign rsp_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_min            <= '0;
      cal_max            <= '1;
      invert_direction   <= 1'b0;
      edge_fraction      <= EDGE_BITS'(3);
      smoothing_coeff    <= COEF_BITS'(204);
      change_threshold   <= prc_pkg::THR_BITS'(8);
      sample_interval_ms <= prc_pkg::MS_BITS'(20);
    end else if (cfg_write) begin
      case (cfg_index)
        prc_pkg::REG_CAL_MIN:   cal_min            <= cfg_data[ADC_BITS-1:0];
        prc_pkg::REG_CAL_MAX:   cal_max            <= cfg_data[ADC_BITS-1:0];
        prc_pkg::REG_INVERT:    invert_direction   <= cfg_data[0];
        prc_pkg::REG_EDGE_FRAC: edge_fraction      <= cfg_data[EDGE_BITS-1:0];
        prc_pkg::REG_SMOOTHING: smoothing_coeff    <= cfg_data[COEF_BITS-1:0];
        prc_pkg::REG_THRESHOLD: change_threshold   <= cfg_data[prc_pkg::THR_BITS-1:0];
        prc_pkg::REG_INTERVAL:  sample_interval_ms <= cfg_data[prc_pkg::MS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      elapsed_ms     <= '0;
      filtered_value <= '0;
      last_reported  <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      // When a new word is loaded in S_WR, that load takes the place of the clear.
      if (rsp_valid && !rsp_stall && state != S_WR) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_take) begin
            res_changed <= 1'b0;
            res_pos     <= '0;
            if (req.op == prc_pkg::OP_TICK) begin
              state <= S_WR;
              if (elapsed_ms != '1) begin
                elapsed_ms <= elapsed_ms + 1'b1;
              end
            end else if (elapsed_ms >= sample_interval_ms) begin
              elapsed_ms <= '0;
              samp       <= samp_cl;
              a_sh       <= SH_W'(1 << COEF_BITS) - SH_W'(smoothing_coeff);
              c_sh       <= SH_W'(smoothing_coeff);
              e_sh       <= SH_W'(edge_fraction);
              acc_f      <= '0;
              acc_t      <= '0;
              cnt        <= CNT_W'(SH_W - 1);
              state      <= S_MUL;
            end else begin
              state <= S_WR;
            end
          end
        end
        S_MUL: begin
          // MSB-first shift-add: one coefficient bit per cycle for both products.
          acc_f <= {acc_f[PROD_W-2:0], 1'b0}
                 + (a_sh[SH_W-1] ? PROD_W'(samp) : PROD_W'(0))
                 + (c_sh[SH_W-1] ? PROD_W'(filtered_value) : PROD_W'(0));
          acc_t <= {acc_t[TRIM_W-2:0], 1'b0}
                 + (e_sh[SH_W-1] ? TRIM_W'(range) : TRIM_W'(0));
          a_sh  <= {a_sh[SH_W-2:0], 1'b0};
          c_sh  <= {c_sh[SH_W-2:0], 1'b0};
          e_sh  <= {e_sh[SH_W-2:0], 1'b0};
          cnt   <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_TRIM;
          end
        end
        S_TRIM: begin
          tmin  <= cal_min + ADC_BITS'(acc_t[TRIM_W-1:COEF_BITS]);
          tmax  <= hi - ADC_BITS'(acc_t[TRIM_W-1:COEF_BITS]);
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (f == last_reported) begin
            filtered_value <= f;
            res_changed    <= 1'b0;
            state          <= S_WR;
          end else if (diff < change_threshold && f < tmax && f > tmin) begin
            filtered_value <= f;
            res_changed    <= 1'b0;
            state          <= S_WR;
          end else if (f < tmin) begin
            // Below the trimmed range the reading snaps to tmin and reports zero, once.
            filtered_value <= tmin;
            state          <= S_WR;
            if (last_reported != tmin) begin
              last_reported <= tmin;
              res_changed   <= 1'b1;
              res_pos       <= '0;
            end
          end else if (f > tmax) begin
            filtered_value <= tmax;
            state          <= S_WR;
            if (last_reported != tmax) begin
              last_reported <= tmax;
              res_changed   <= 1'b1;
              res_pos       <= '1;
            end
          end else begin
            filtered_value <= f;
            last_reported  <= f;
            res_changed    <= 1'b1;
            if (tmax == tmin) begin
              res_pos <= '0;
              state   <= S_WR;
            end else if (f == tmax) begin
              res_pos <= '1;
              state   <= S_WR;
            end else begin
              rem   <= f - tmin;
              den   <= tmax - tmin;
              quo   <= '0;
              cnt   <= CNT_W'(FRAC_BITS - 1);
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle; rem stays below den.
          rem <= ge ? ADC_BITS'(rem2 - {1'b0, den}) : rem2[ADC_BITS-1:0];
          quo <= {quo[FRAC_BITS-2:0], ge};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            res_pos <= {quo[FRAC_BITS-2:0], ge};
            state   <= S_WR;
          end
        end
        S_WR: begin
          if (rsp_free) begin
            rsp_valid    <= 1'b1;
            rsp.changed  <= res_changed;
            rsp.position <= (res_changed && invert_direction) ? ~res_pos : res_pos;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_take_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req_take |=> state != S_IDLE)
    else $error("accepted word did not start work");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR && rsp_free) |=> rsp_valid && state == S_IDLE)
    else $error("finished word was not moved to the output register");

  a_quiet_is_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.changed) |-> rsp.position == '0)
    else $error("unchanged word carries a nonzero position");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < den)
    else $error("division remainder reached the divisor");
`endif

endmodule

/* bench/prc_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prc_checker: response checker for the pot reading conditioner
// Mirrors the register writes, predicts the response word of every accepted
// request word and compares it, field by field, with the words that leave the
// block in order.
// ----------------------------------------------------------------------------
module prc_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  input  logic                           req_stall,
  input  prc_pkg::req_word_t             req,
  input  logic                           rsp_valid,
  input  logic                           rsp_stall,
  input  prc_pkg::rsp_word_t             rsp,
  input  logic                           cfg_write,
  input  logic [prc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatch_count,
  output int                             words_pending
);

  localparam int ADC_BITS  = prc_pkg::ADC_BITS;
  localparam int FRAC_BITS = prc_pkg::FRAC_BITS;
  localparam int EDGE_BITS = prc_pkg::EDGE_BITS;
  localparam int COEF_BITS = prc_pkg::COEF_BITS;
  localparam int THR_BITS  = prc_pkg::THR_BITS;
  localparam int MS_BITS   = prc_pkg::MS_BITS;
  localparam int unsigned FULL_SCALE = (1 << FRAC_BITS) - 1;

  // Register copies.
  logic [ADC_BITS-1:0]  cal_lo;
  logic [ADC_BITS-1:0]  cal_hi;
  logic                 invert_dir;
  logic [EDGE_BITS-1:0] edge_frac;
  logic [COEF_BITS-1:0] coeff;
  logic [THR_BITS-1:0]  threshold;
  logic [MS_BITS-1:0]   interval_ms;

  // Conditioner state.
  logic [MS_BITS-1:0]   ms_count;
  logic [ADC_BITS-1:0]  smooth_value;
  logic [ADC_BITS-1:0]  reported_value;

  prc_pkg::rsp_word_t expected_words[$];
  int                 fails = 0;
  int                 pending = 0;

  assign mismatch_count = fails;
  assign words_pending  = pending;

  function automatic prc_pkg::rsp_word_t condition_reading(prc_pkg::req_word_t w);
    prc_pkg::rsp_word_t r;
    int unsigned lo, hi, trim, tmin, tmax, s, c, f, diff, frac;
    r = '0;
    if (w.op == prc_pkg::OP_TICK) begin
      if (ms_count != '1) ms_count = ms_count + 1'b1;
      return r;
    end
    if (ms_count < interval_ms) return r;
    ms_count = '0;

    // An upside-down calibration collapses to an empty range at cal_min.
    lo   = cal_lo;
    hi   = (cal_hi < cal_lo) ? cal_lo : cal_hi;
    trim = ((hi - lo) * edge_frac) >> 8;
    tmin = lo + trim;
    tmax = hi - trim;

    s = w.adc_sample;
    if (s < lo) s = lo;
    if (s > hi) s = hi;
    c = coeff;
    f = (((256 - c) * s + c * smooth_value) >> 8) & 32'hFFF;
    smooth_value = f[ADC_BITS-1:0];

    if (f == reported_value) return r;
    diff = (f > reported_value) ? f - reported_value : reported_value - f;
    if (diff < threshold && f < tmax && f > tmin) return r;

    // Past the trimmed limits the reading snaps to the limit and reports once.
    if (f < tmin) begin
      smooth_value = tmin[ADC_BITS-1:0];
      if (reported_value == tmin) return r;
      reported_value = tmin[ADC_BITS-1:0];
      frac = 0;
    end else if (f > tmax) begin
      smooth_value = tmax[ADC_BITS-1:0];
      if (reported_value == tmax) return r;
      reported_value = tmax[ADC_BITS-1:0];
      frac = FULL_SCALE;
    end else begin
      reported_value = f[ADC_BITS-1:0];
      if (tmax == tmin) begin
        frac = 0;
      end else begin
        frac = ((f - tmin) << FRAC_BITS) / (tmax - tmin);
        if (frac > FULL_SCALE) frac = FULL_SCALE;
      end
    end
    if (invert_dir) frac = FULL_SCALE - frac;

    r.changed  = 1'b1;
    r.position = frac[FRAC_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    prc_pkg::rsp_word_t want;
    if (rst) begin
      cal_lo         <= '0;
      cal_hi         <= 12'd4095;
      invert_dir     <= 1'b0;
      edge_frac      <= 7'd3;
      coeff          <= 8'd204;
      threshold      <= 12'd8;
      interval_ms    <= 16'd20;
      ms_count       = '0;
      smooth_value   = '0;
      reported_value = '0;
      expected_words.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          prc_pkg::REG_CAL_MIN:   cal_lo      <= cfg_data[ADC_BITS-1:0];
          prc_pkg::REG_CAL_MAX:   cal_hi      <= cfg_data[ADC_BITS-1:0];
          prc_pkg::REG_INVERT:    invert_dir  <= cfg_data[0];
          prc_pkg::REG_EDGE_FRAC: edge_frac   <= cfg_data[EDGE_BITS-1:0];
          prc_pkg::REG_SMOOTHING: coeff       <= cfg_data[COEF_BITS-1:0];
          prc_pkg::REG_THRESHOLD: threshold   <= cfg_data[THR_BITS-1:0];
          prc_pkg::REG_INTERVAL:  interval_ms <= cfg_data[MS_BITS-1:0];
          default: ;
        endcase
      end
      if (rsp_valid && !rsp_stall) begin
        if (expected_words.size() == 0) begin
          if (fails < 10)
            $display("%0t: response word with none expected: changed=%0d position=%0d",
                     $time, rsp.changed, rsp.position);
          fails = fails + 1;
        end else begin
          want = expected_words.pop_front();
          if (want.changed !== rsp.changed || want.position !== rsp.position) begin
            if (fails < 10)
              $display({"%0t: mismatch: expected changed=%0d position=%0d, ",
                        "got changed=%0d position=%0d"},
                       $time, want.changed, want.position, rsp.changed, rsp.position);
            fails = fails + 1;
          end
        end
      end
      if (req_valid && !req_stall) expected_words.push_back(condition_reading(req));
    end
    pending <= expected_words.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the pot reading conditioner
// Drives ticks and polls through a directed opening and random phases under
// changing register settings, with random idle bursts on both channels;
// the checker judges each word.
// ----------------------------------------------------------------------------
module tb_top;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           req_valid = 1'b0;
  logic                           req_stall;
  prc_pkg::req_word_t             req = '0;
  logic                           rsp_valid;
  logic                           rsp_stall = 1'b0;
  prc_pkg::rsp_word_t             rsp;
  logic                           cfg_write = 1'b0;
  logic [prc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [prc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int          mismatch_count;
  int          words_pending;
  bit          idle_on = 1'b1;
  int          stall_left = 0;
  int          knob = 2048;
  int          sent = 0;
  int unsigned cur_interval;
  int unsigned cur_lo;
  int unsigned cur_hi;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pot_reading_conditioner dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  prc_checker check (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp            (rsp),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  // Receiver stalls come in bursts of random length while idle_on is set.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 13);
      rsp_stall  <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  task automatic write_reg(input logic [prc_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[prc_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every expected word has come back and the block is idle.
  task automatic settle();
    req_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input int unsigned lo, input int unsigned hi,
                              input int unsigned inv, input int unsigned edge_frac,
                              input int unsigned coeff, input int unsigned thr,
                              input int unsigned interval);
    settle();
    write_reg(prc_pkg::REG_CAL_MIN, lo);
    write_reg(prc_pkg::REG_CAL_MAX, hi);
    write_reg(prc_pkg::REG_INVERT, inv);
    write_reg(prc_pkg::REG_EDGE_FRAC, edge_frac);
    write_reg(prc_pkg::REG_SMOOTHING, coeff);
    write_reg(prc_pkg::REG_THRESHOLD, thr);
    write_reg(prc_pkg::REG_INTERVAL, interval);
    cur_lo       = lo;
    cur_hi       = hi;
    cur_interval = interval;
  endtask

  // Valid stays high from one word to the next unless a gap is taken.
  task automatic send_word(input logic op, input int unsigned sample);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_valid      <= 1'b1;
    req.op         <= op;
    req.adc_sample <= sample[prc_pkg::ADC_BITS-1:0];
    sent = sent + 1;
    do @(posedge clk); while (req_stall);
  endtask

  function automatic int unsigned pick_value(input int unsigned maxval);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return maxval;
      default: return $urandom_range(0, maxval);
    endcase
  endfunction

  // A run of ticks near the sample interval followed by one poll; sometimes
  // the poll comes early on purpose.
  task automatic poll_sequence();
    int unsigned ticks;
    int unsigned sample;
    if (cur_interval > 100) ticks = $urandom_range(0, 5);
    else if ($urandom_range(0, 5) == 0) ticks = $urandom_range(0, cur_interval);
    else ticks = cur_interval + $urandom_range(0, 2);
    repeat (ticks) send_word(prc_pkg::OP_TICK, $urandom_range(0, 4095));

    if ($urandom_range(0, 1) == 1) knob = knob + int'($urandom_range(0, 20)) - 10;
    else knob = knob + int'($urandom_range(0, 600)) - 300;
    if (knob < 0) knob = 0;
    if (knob > 4095) knob = 4095;
    case ($urandom_range(0, 9))
      0:       sample = $urandom_range(0, 4095);
      1:       sample = cur_lo;
      2:       sample = cur_hi;
      3:       sample = $urandom_range(0, 1) ? 4095 : 0;
      default: sample = unsigned'(knob);
    endcase
    send_word(prc_pkg::OP_POLL, sample);
  endtask

  initial begin
    int phase_end;
    int unsigned lo, hi, thr, interval;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Straight mapping without smoothing: snaps at both limits, exact limits,
    // a suppressed small step and ticks.
    apply_config(100, 4000, 0, 3, 0, 8, 0);
    send_word(prc_pkg::OP_POLL, 0);
    send_word(prc_pkg::OP_POLL, 0);
    send_word(prc_pkg::OP_POLL, 4095);
    send_word(prc_pkg::OP_POLL, 4095);
    send_word(prc_pkg::OP_POLL, 2000);
    send_word(prc_pkg::OP_POLL, 3955);
    send_word(prc_pkg::OP_POLL, 2000);
    send_word(prc_pkg::OP_POLL, 2003);
    send_word(prc_pkg::OP_POLL, 145);
    send_word(prc_pkg::OP_TICK, 4095);
    send_word(prc_pkg::OP_TICK, 0);

    // Upside-down calibration gives an empty range, reported inverted.
    apply_config(3000, 1000, 1, 3, 0, 8, 0);
    send_word(prc_pkg::OP_POLL, 500);
    send_word(prc_pkg::OP_POLL, 4095);

    // Interval gating with heavy smoothing and the widest trim.
    apply_config(0, 4095, 0, 127, 255, 4095, 3);
    send_word(prc_pkg::OP_POLL, 1000);
    repeat (3) send_word(prc_pkg::OP_TICK, 0);
    send_word(prc_pkg::OP_POLL, 4095);
    send_word(prc_pkg::OP_POLL, 0);

    for (int p = 0; p < 14; p++) begin
      idle_on = (p < 11);
      if (p == 0) begin
        apply_config(0, 0, 0, 0, 0, 0, 0);
      end else if (p == 1) begin
        apply_config(4095, 4095, 1, 127, 255, 4095, 65535);
      end else begin
        lo = pick_value(4095);
        hi = pick_value(4095);
        if (hi < lo && $urandom_range(0, 3) != 0) begin
          hi = lo;
          lo = pick_value(hi);
        end
        thr = ($urandom_range(0, 3) == 0) ? pick_value(4095) : $urandom_range(0, 64);
        interval = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
        apply_config(lo, hi, $urandom_range(0, 1), pick_value(127), pick_value(255),
                     thr, interval);
      end
      phase_end = sent + 102;
      while (sent < phase_end) poll_sequence();
    end

    settle();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && words_pending == 0)
      $display("** pot_reading_conditioner: PASSED **");
    else
      $display("** pot_reading_conditioner: FAILED **");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("** pot_reading_conditioner: FAILED **");
    $finish;
  end

endmodule
